// ===== hw/rtl/rdc_pkg.sv =====
// rdc_pkg: shared types, sizes and the microcode program of the radix digit converter
// used by rdc_div, rdc_seq and radix_digit_converter_unit; no dependencies
package rdc_pkg;

  localparam int unsigned VALUE_WIDTH = 31;
  localparam int unsigned STACK_DEPTH = 31;
  localparam int unsigned DIGIT_WIDTH = 8;
  localparam int unsigned RADIX_WIDTH = 8;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned ITER_W      = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned STEP_W      = 4;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
  } rdc_in_t;

  typedef struct packed {
    logic [DIGIT_WIDTH-1:0] digit;
    logic                   has_digit;
    logic                   bad_radix;
    logic                   last;
  } rdc_out_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_PUSH,
    OP_READ,
    OP_EMIT_DIGIT,
    OP_EMIT_BAD,
    OP_EMIT_ZERO
  } op_e;

  // jump condition of one step; no jump means fall through to the next step
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD_RADIX,
    COND_ZERO,
    COND_DIV_BUSY,
    COND_QUOT_NZ,
    COND_OUT_BUSY,
    COND_STACK_NZ
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_CHK_RADIX = 4'd1;
  localparam step_t STEP_CHK_ZERO  = 4'd2;
  localparam step_t STEP_DIV_START = 4'd3;
  localparam step_t STEP_DIV_WAIT  = 4'd4;
  localparam step_t STEP_PUSH      = 4'd5;
  localparam step_t STEP_POP_READ  = 4'd6;
  localparam step_t STEP_POP_EMIT  = 4'd7;
  localparam step_t STEP_POP_LOOP  = 4'd8;
  localparam step_t STEP_POP_DONE  = 4'd9;
  localparam step_t STEP_BAD_EMIT  = 4'd10;
  localparam step_t STEP_BAD_DONE  = 4'd11;
  localparam step_t STEP_ZERO_EMIT = 4'd12;
  localparam step_t STEP_ZERO_DONE = 4'd13;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // datapath flags the sequencer tests
  typedef struct packed {
    logic in_valid;
    logic bad_radix;
    logic zero;
    logic div_busy;
    logic quot_nz;
    logic out_busy;
    logic stack_nz;
  } seq_status_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:      w = '{op: OP_LOAD,       cond: COND_NO_INPUT,  target: STEP_IDLE};
      STEP_CHK_RADIX: w = '{op: OP_NOP,        cond: COND_BAD_RADIX, target: STEP_BAD_EMIT};
      STEP_CHK_ZERO:  w = '{op: OP_NOP,        cond: COND_ZERO,      target: STEP_ZERO_EMIT};
      STEP_DIV_START: w = '{op: OP_DIV,        cond: COND_NEXT,      target: STEP_IDLE};
      STEP_DIV_WAIT:  w = '{op: OP_NOP,        cond: COND_DIV_BUSY,  target: STEP_DIV_WAIT};
      STEP_PUSH:      w = '{op: OP_PUSH,       cond: COND_QUOT_NZ,   target: STEP_DIV_START};
      STEP_POP_READ:  w = '{op: OP_READ,       cond: COND_NEXT,      target: STEP_IDLE};
      STEP_POP_EMIT:  w = '{op: OP_EMIT_DIGIT, cond: COND_OUT_BUSY,  target: STEP_POP_EMIT};
      STEP_POP_LOOP:  w = '{op: OP_NOP,        cond: COND_STACK_NZ,  target: STEP_POP_READ};
      STEP_POP_DONE:  w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: STEP_IDLE};
      STEP_BAD_EMIT:  w = '{op: OP_EMIT_BAD,   cond: COND_OUT_BUSY,  target: STEP_BAD_EMIT};
      STEP_BAD_DONE:  w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: STEP_IDLE};
      STEP_ZERO_EMIT: w = '{op: OP_EMIT_ZERO,  cond: COND_OUT_BUSY,  target: STEP_ZERO_EMIT};
      STEP_ZERO_DONE: w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: STEP_IDLE};
      default:        w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/rdc_ram.sv =====
// rdc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rdc_div.sv =====
// rdc_div: restoring divider, one quotient bit per cycle, value by radix
// depends on rdc_pkg
module rdc_div
  import rdc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] quot_o,
  output logic [RADIX_WIDTH-1:0] rem_o
);

  logic                   busy_q, busy_d;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [RADIX_WIDTH-1:0] rem_q, rem_d;
  logic [RADIX_WIDTH-1:0] divisor_q, divisor_d;
  logic [RADIX_WIDTH:0]   rem_shift;
  logic [RADIX_WIDTH:0]   diff;
  logic                   ge;

  always_comb begin
    rem_shift = {rem_q, quot_q[VALUE_WIDTH-1]};
    ge        = rem_shift >= {1'b0, divisor_q};
    diff      = rem_shift - {1'b0, divisor_q};
    busy_d    = busy_q;
    iter_d    = iter_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      iter_d    = ITER_W'(VALUE_WIDTH);
      quot_d    = dividend_i;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the low bits
      rem_d  = ge ? diff[RADIX_WIDTH-1:0] : rem_shift[RADIX_WIDTH-1:0];
      quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      iter_d = iter_q - ITER_W'(1);
      busy_d = iter_q != ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/rdc_seq.sv =====
// rdc_seq: step counter and microcode table lookup with conditional jumps
// depends on rdc_pkg
module rdc_seq
  import rdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ucode_t      ctrl_o,
  output step_t       step_o
);

  step_t  step_q, step_d;
  ucode_t ctrl;
  logic   take;

  always_comb begin
    ctrl = ucode_rom(step_q);
    unique case (ctrl.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !status_i.in_valid;
      COND_BAD_RADIX: take = status_i.bad_radix;
      COND_ZERO:      take = status_i.zero;
      COND_DIV_BUSY:  take = status_i.div_busy;
      COND_QUOT_NZ:   take = status_i.quot_nz;
      COND_OUT_BUSY:  take = status_i.out_busy;
      COND_STACK_NZ:  take = status_i.stack_nz;
      default:        take = 1'b1;
    endcase
    step_d = take ? ctrl.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign step_o = step_q;

endmodule

// ===== hw/rtl/radix_digit_converter_unit.sv =====
// radix_digit_converter_unit: top level, datapath around the microcode sequencer
// depends on rdc_pkg, rdc_seq, rdc_div and rdc_ram
//
// Usage: one input word carries a value and a radix. The block answers with a
// run of output words, one digit each, most significant digit first, the final
// word of the run marked with last. A zero value gives a single word without a
// digit; a radix below 2 gives a single word with bad_radix set.
// Both channels use valid/stall; a word moves at an edge with valid high and
// stall low. in_stall_o is low only while the sequencer sits in its idle step.
// Each digit takes one pass through the bit-serial divider, and each pop
// passes through a read step and an emit step into the output register. The
// divider sets the pace.
// Stall: the output register holds its word while out_stall_i is high; the
// sequencer waits in its emit step. After the last word of a run, the loop
// and done steps come before the next input, only done for a bad radix or zero.
// Reset: asynchronous, active low; the block comes up idle with an empty
// output register. The digit store needs no clearing.
module radix_digit_converter_unit
  import rdc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rdc_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rdc_out_t out_o
);

  ucode_t                 ctrl;
  step_t                  step;
  seq_status_t            status;
  logic                   in_accept;
  logic                   out_busy;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [RADIX_WIDTH-1:0] radix_q, radix_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  rdc_out_t               out_q, out_d;
  logic                   div_start;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_WIDTH-1:0] div_rem;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [CNT_W-1:0]       cnt_dec;
  logic [DIGIT_WIDTH-1:0] ram_rdata;

  rdc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .step_o   (step)
  );

  rdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (value_q),
    .divisor_i  (radix_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rdc_ram #(
    .WIDTH (DIGIT_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = ctrl.op != OP_LOAD;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign div_start  = ctrl.op == OP_DIV;
  assign cnt_dec    = cnt_q - CNT_W'(1);

  // pushes beyond the stack depth are dropped
  assign ram_we    = (ctrl.op == OP_PUSH) && (cnt_q < CNT_W'(STACK_DEPTH));
  assign ram_waddr = cnt_q[ADDR_W-1:0];
  assign ram_re    = ctrl.op == OP_READ;
  assign ram_raddr = cnt_dec[ADDR_W-1:0];

  always_comb begin
    status.in_valid  = in_valid_i;
    status.bad_radix = radix_q < RADIX_MIN;
    status.zero      = value_q == '0;
    status.div_busy  = div_busy;
    status.quot_nz   = div_quot != '0;
    status.out_busy  = out_busy;
    status.stack_nz  = cnt_q != '0;
  end

  always_comb begin
    value_d     = value_q;
    radix_d     = radix_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (ctrl.op) inside
      OP_LOAD: begin
        if (in_accept) begin
          value_d = in_i.value;
          radix_d = in_i.radix;
          cnt_d   = '0;
        end
      end
      OP_PUSH: begin
        value_d = div_quot;
        if (ram_we) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_READ: cnt_d = cnt_dec;
      OP_EMIT_DIGIT, OP_EMIT_BAD, OP_EMIT_ZERO: begin
        if (!out_busy) begin
          out_valid_d     = 1'b1;
          out_d.digit     = (ctrl.op == OP_EMIT_DIGIT) ? ram_rdata : '0;
          out_d.has_digit = ctrl.op == OP_EMIT_DIGIT;
          out_d.bad_radix = ctrl.op == OP_EMIT_BAD;
          // count was already lowered by the read step
          out_d.last      = (ctrl.op != OP_EMIT_DIGIT) || (cnt_q == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    radix_q <= radix_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> step == STEP_CHK_RADIX)
    else $error("accepted word did not start the radix check");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("digit count beyond stack depth");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_bad_word_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.bad_radix) |-> (out_o.last && !out_o.has_digit))
    else $error("bad radix word not a single last word");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> cnt_q != '0)
    else $error("pop from empty digit stack");
`endif

endmodule
